>>> rtl/ttdt_pkg.sv
// shared types and constants for the tick deadline tracker
package ttdt_pkg;

   localparam int CNT_WIDTH = 64;
   localparam int PER_WIDTH = 32;
   localparam int IDLE_WIDTH = 32;
   localparam int TICKS_WIDTH = 32;

   localparam logic [PER_WIDTH-1:0] CPT_RESET = 32'd144000;
   localparam int TICK_COUNT_WIDTH_DEF = 32;

   localparam int DIV_STEPS = 64;
   localparam int MUL_STEPS = 32;

   typedef enum logic [1:0] {
      FN_START = 2'd0,
      FN_TICK  = 2'd1,
      FN_SLEEP = 2'd2,
      FN_WAKE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_DIVRES,
      ST_STEP,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic mul;
   } arith_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_sts_type;

endpackage

>>> rtl/ttdt_arith.sv
// shared shift-add multiplier and restoring divider, one step per cycle
module ttdt_arith
   import ttdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  arith_cmd_type         cmd,
   input  logic [CNT_WIDTH-1:0]  op_a,
   input  logic [PER_WIDTH-1:0]  op_b,
   output arith_sts_type         sts,
   output logic [CNT_WIDTH-1:0]  quo,
   output logic [PER_WIDTH-1:0]  rem,
   output logic [CNT_WIDTH-1:0]  prod
);

   localparam int STEP_W = $clog2(DIV_STEPS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  mul_ff, mul_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic [PER_WIDTH:0]    acc_ff, acc_in;
   logic [CNT_WIDTH-1:0]  sh_ff, sh_in;
   logic [PER_WIDTH-1:0]  b_ff, b_in;

   logic [PER_WIDTH:0]    trial;
   logic [PER_WIDTH:0]    add_a;
   logic [PER_WIDTH:0]    add_b;
   logic                  cin;
   logic [PER_WIDTH+1:0]  sum;
   logic                  no_borrow;

   // one adder serves both operations
   always_comb begin
      trial = {acc_ff[PER_WIDTH-1:0], sh_ff[CNT_WIDTH-1]};
      if (mul_ff) begin
         add_a = {1'b0, acc_ff[PER_WIDTH-1:0]};
         add_b = sh_ff[0] ? {1'b0, b_ff} : '0;
         cin   = 1'b0;
      end else begin
         add_a = trial;
         add_b = ~{1'b0, b_ff};
         cin   = 1'b1;
      end
      sum = {1'b0, add_a} + {1'b0, add_b} + {{(PER_WIDTH+1){1'b0}}, cin};
      no_borrow = sum[PER_WIDTH+1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mul_in  = mul_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      b_in    = b_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         mul_in  = cmd.mul;
         cnt_in  = cmd.mul ? STEP_W'(MUL_STEPS - 1) : STEP_W'(DIV_STEPS - 1);
         acc_in  = '0;
         sh_in   = op_a;
         b_in    = op_b;
      end else if (busy_ff) begin
         if (mul_ff) begin
            acc_in = {1'b0, sum[PER_WIDTH:1]};
            sh_in  = {sh_ff[CNT_WIDTH-1:PER_WIDTH], sum[0], sh_ff[PER_WIDTH-1:1]};
         end else begin
            acc_in = no_borrow ? sum[PER_WIDTH:0] : trial;
            sh_in  = {sh_ff[CNT_WIDTH-2:0], no_borrow};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mul_ff <= mul_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      b_ff   <= b_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo  = sh_ff;
   assign rem  = acc_ff[PER_WIDTH-1:0];
   assign prod = {acc_ff[PER_WIDTH-1:0], sh_ff[PER_WIDTH-1:0]};

endmodule

>>> rtl/tickless_tick_deadline_tracker.sv
// tick deadline tracker top level: sequencer, deadline state and output register
// start, short sleep or a deadline not reached go straight to the result; sleep begin
// runs a multiply; tick runs a divide; wake runs a divide, then a multiply when clamped
// one word at a time, the next is taken once the result sits in the output register;
// the shared arithmetic unit runs the 64-step divide and the 32-step multiply
// synchronous reset: period 144000, deadline and saved idle zero, no result pending
module tickless_tick_deadline_tracker
   import ttdt_pkg::*;
#(
   parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // func, counter_now, idle_ticks
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata    // compare_value, ticks_elapsed
);

   localparam logic [CNT_WIDTH-1:0] TICK_LIM = (64'd1 << TICK_COUNT_WIDTH) - 64'd1;

   state_type              state_ff, state_in;
   logic [PER_WIDTH-1:0]   cpt_ff, cpt_in;
   logic [CNT_WIDTH-1:0]   dl_ff, dl_in;
   logic [IDLE_WIDTH-1:0]  saved_ff, saved_in;
   logic [PER_WIDTH-1:0]   per_ff, per_in;
   func_type               func_ff, func_in;
   logic [CNT_WIDTH-1:0]   now_ff, now_in;
   logic [CNT_WIDTH-1:0]   n_ff, n_in;
   logic [CNT_WIDTH-1:0]   base_ff, base_in;
   logic [CNT_WIDTH-1:0]   cmp_ff, cmp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CNT_WIDTH-1:0]   rsp_cmp_ff, rsp_cmp_in;
   logic [TICKS_WIDTH-1:0] rsp_ticks_ff, rsp_ticks_in;

   func_type               req_func;
   logic [CNT_WIDTH-1:0]   req_now;
   logic [IDLE_WIDTH-1:0]  req_idle;
   logic                   req_acc;
   logic [PER_WIDTH-1:0]   per_cur;
   logic [CNT_WIDTH-1:0]   diff;
   logic                   reached;
   logic [CNT_WIDTH-1:0]   q_inc;
   logic [CNT_WIDTH-1:0]   n_sat;
   logic                   out_free;

   arith_cmd_type          a_cmd;
   arith_sts_type          a_sts;
   logic [CNT_WIDTH-1:0]   a_op_a;
   logic [PER_WIDTH-1:0]   a_op_b;
   logic [CNT_WIDTH-1:0]   a_quo;
   logic [PER_WIDTH-1:0]   a_rem;
   logic [CNT_WIDTH-1:0]   a_prod;

   ttdt_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (a_cmd),
      .op_a  (a_op_a),
      .op_b  (a_op_b),
      .sts   (a_sts),
      .quo   (a_quo),
      .rem   (a_rem),
      .prod  (a_prod)
   );

   assign req_func = func_type'(req_tdata[1:0]);
   assign req_now  = req_tdata[65:2];
   assign req_idle = req_tdata[97:66];
   assign req_acc  = req_tvalid && req_tready;
   assign per_cur  = (cpt_ff == '0) ? PER_WIDTH'(1) : cpt_ff;
   assign diff     = req_now - dl_ff;
   assign reached  = req_now >= dl_ff;
   assign q_inc    = (&a_quo) ? a_quo : a_quo + 64'd1;
   assign n_sat    = (n_ff > TICK_LIM) ? TICK_LIM : n_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_func)
                  FN_START: state_in = ST_DONE;
                  FN_TICK, FN_WAKE: state_in = reached ? ST_DIV : ST_DONE;
                  FN_SLEEP: state_in = (req_idle > 32'd1) ? ST_MUL : ST_DONE;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_DIV: begin
            if (a_sts.done) begin
               state_in = ST_DIVRES;
            end
         end
         ST_DIVRES: begin
            if (func_ff == FN_WAKE && a_quo >= {32'd0, saved_ff}) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: state_in = ST_DONE;
         ST_MUL: begin
            if (a_sts.done) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and unit control
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      cpt_in       = csr_wr_en ? csr_wr_data : cpt_ff;
      dl_in        = dl_ff;
      saved_in     = saved_ff;
      per_in       = per_ff;
      func_in      = func_ff;
      now_in       = now_ff;
      n_in         = n_ff;
      base_in      = base_ff;
      cmp_in       = cmp_ff;
      rsp_cmp_in   = rsp_cmp_ff;
      rsp_ticks_in = rsp_ticks_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      a_cmd.start  = 1'b0;
      a_cmd.mul    = 1'b0;
      a_op_a       = diff;
      a_op_b       = per_cur;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               per_in  = per_cur;
               func_in = req_func;
               now_in  = req_now;
               n_in    = '0;
               cmp_in  = dl_ff;
               unique case (req_func)
                  FN_START: begin
                     dl_in  = req_now + {32'd0, per_cur};
                     cmp_in = req_now + {32'd0, per_cur};
                  end
                  FN_TICK, FN_WAKE: begin
                     a_cmd.start = reached;
                  end
                  FN_SLEEP: begin
                     saved_in    = req_idle;
                     a_cmd.start = req_idle > 32'd1;
                     a_cmd.mul   = 1'b1;
                     a_op_a      = {32'd0, req_idle - 32'd1};
                  end
                  default: ;
               endcase
            end
         end
         ST_DIVRES: begin
            base_in = now_ff - {32'd0, a_rem};
            if (func_ff == FN_WAKE && a_quo >= {32'd0, saved_ff}) begin
               n_in        = {32'd0, saved_ff};
               a_cmd.start = 1'b1;
               a_cmd.mul   = 1'b1;
               a_op_a      = {32'd0, saved_ff};
               a_op_b      = per_ff;
            end else begin
               n_in = q_inc;
            end
         end
         ST_STEP: begin
            dl_in  = base_ff + {32'd0, per_ff};
            cmp_in = base_ff + {32'd0, per_ff};
         end
         ST_ADD: begin
            cmp_in = dl_ff + a_prod;
            if (func_ff == FN_WAKE) begin
               dl_in = dl_ff + a_prod;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cmp_in   = cmp_ff;
               rsp_ticks_in = n_sat[TICKS_WIDTH-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cpt_ff       <= CPT_RESET;
         dl_ff        <= '0;
         saved_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cpt_ff       <= cpt_in;
         dl_ff        <= dl_in;
         saved_ff     <= saved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      per_ff       <= per_in;
      func_ff      <= func_in;
      now_ff       <= now_in;
      n_ff         <= n_in;
      base_ff      <= base_in;
      cmp_ff       <= cmp_in;
      rsp_cmp_ff   <= rsp_cmp_in;
      rsp_ticks_ff <= rsp_ticks_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ticks_ff, rsp_cmp_ff};

endmodule

>>> rtl/ttdt_checker.sv
// port-level checks for the tick deadline tracker, bound to the top level
module ttdt_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [95:0]  rsp_tdata
);

   // nothing pending and ready for a word after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   // busy once a word is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("ready held after word accepted");

   // a fresh result appears only as the sequencer goes back to waiting
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result raised while busy");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind tickless_tick_deadline_tracker ttdt_checker u_ttdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> sim/tb_top.sv
// self-checking testbench for the tick deadline tracker: shadow predictor, stream drivers
module tb_top;
   import ttdt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [63:0] cmp;
      logic [31:0] ticks;
   } tick_result_type;

   class deadline_shadow;
      logic [31:0]  period;
      logic [63:0]  deadline;
      logic [31:0]  saved_idle;
      tick_result_type awaited[$];
      int           mismatches;
      int           results_seen;
      int           fn_count[4];
      int           saturated;
      int           clamped;

      function new();
         period = CPT_RESET;
         deadline = '0;
         saved_idle = '0;
         mismatches = 0;
         results_seen = 0;
         saturated = 0;
         clamped = 0;
         foreach (fn_count[i]) fn_count[i] = 0;
      endfunction

      function logic [63:0] eff_period();
         return (period == '0) ? 64'd1 : {32'd0, period};
      endfunction

      function logic [31:0] sat_ticks(input logic [63:0] n);
         logic [63:0] lim;
         lim = {64{1'b1}} >> (64 - TICK_COUNT_WIDTH_DEF);
         if (n > lim) begin
            saturated++;
            return lim[31:0];
         end
         return n[31:0];
      endfunction

      function void note_event(input logic [1:0] fn, input logic [63:0] cnt,
                               input logic [31:0] idle);
         logic [63:0]  p;
         logic [63:0]  q;
         logic [63:0]  n;
         tick_result_type r;
         p = eff_period();
         r.ticks = '0;
         fn_count[fn]++;
         case (func_type'(fn))
            FN_START: begin
               deadline = cnt + p;
               r.cmp = deadline;
            end
            FN_TICK: begin
               if (cnt >= deadline) begin
                  q = (cnt - deadline) / p;
                  n = (q == {64{1'b1}}) ? q : q + 64'd1;
                  deadline = deadline + q * p + p;
                  r.ticks = sat_ticks(n);
               end
               r.cmp = deadline;
            end
            FN_SLEEP: begin
               r.cmp = deadline;
               if (idle > 32'd1) r.cmp = r.cmp + {32'd0, idle - 32'd1} * p;
               saved_idle = idle;
            end
            default: begin
               if (cnt >= deadline) begin
                  q = (cnt - deadline) / p;
                  if (q >= {32'd0, saved_idle}) begin
                     n = {32'd0, saved_idle};
                     clamped++;
                  end else begin
                     n = q + 64'd1;
                  end
                  deadline = deadline + n * p;
                  r.ticks = sat_ticks(n);
               end
               r.cmp = deadline;
            end
         endcase
         awaited.push_back(r);
      endfunction

      function void check_result(input logic [63:0] cmp, input logic [31:0] ticks);
         tick_result_type e;
         results_seen++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result word with nothing awaited: cmp %h ticks %h",
                        $realtime, cmp, ticks);
            return;
         end
         e = awaited.pop_front();
         if (cmp !== e.cmp || ticks !== e.ticks) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch: cmp %h ticks %h, expected cmp %h ticks %h",
                        $realtime, cmp, ticks, e.cmp, e.ticks);
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic [31:0]  csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;   // func, counter_now, idle_ticks
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;   // compare_value, ticks_elapsed

   deadline_shadow sb = new();
   bit             quiet;
   bit             long_hold_req;
   logic [1:0]     last_fn;
   int             settings_used;

   tickless_tick_deadline_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #15_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[63:0], rsp_tdata[95:64]);
      if (!reset && req_tvalid && req_tready)
         sb.note_event(req_tdata[1:0], req_tdata[65:2], req_tdata[97:66]);
   end

   function int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   function logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   task automatic send_word(input logic [103:0] w, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic issue(input logic [1:0] fn, input logic [63:0] cnt,
                        input logic [31:0] idle);
      send_word({6'd0, idle, cnt, fn}, pick_gap());
   endtask

   task automatic settle_inputs();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   task automatic write_period(input logic [31:0] v);
      settle_inputs();
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.period = v;
      settings_used++;
   endtask

   task automatic next_random_word(output logic [103:0] w);
      logic [1:0]  fn;
      logic [63:0] cnt;
      logic [63:0] p;
      logic [31:0] idle;
      int          r;
      p = sb.eff_period();
      idle = $urandom;
      cnt = rand64();
      if ($urandom_range(0, 99) < 10) begin
         fn = 2'($urandom_range(0, 3));
      end else begin
         r = $urandom_range(0, 99);
         if (last_fn == FN_SLEEP && $urandom_range(0, 3) != 0) fn = FN_WAKE;
         else if (r < 8) fn = FN_START;
         else if (r < 48) fn = FN_TICK;
         else if (r < 70) fn = FN_SLEEP;
         else fn = FN_WAKE;
         case (func_type'(fn))
            FN_START: begin
               case ($urandom_range(0, 3))
                  0: cnt = {64{1'b1}} - $urandom_range(0, 200000);
                  1: cnt = 64'($urandom_range(0, 1000));
                  default: cnt = rand64();
               endcase
            end
            FN_SLEEP: begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: idle = $urandom_range(0, 3);
                  8: idle = $urandom;
                  9: idle = 32'hFFFF_FFFF - $urandom_range(0, 3);
                  default: idle = $urandom_range(2, 40);
               endcase
            end
            default: begin
               case ($urandom_range(0, 9))
                  0: cnt = sb.deadline - $urandom_range(1, 1000);
                  1: cnt = sb.deadline;
                  7: cnt = sb.deadline + ({32'd0, sb.saved_idle} + $urandom_range(0, 2) - 1) * p
                           + ($urandom % p);
                  8: cnt = sb.deadline + (rand64() >> $urandom_range(0, 63));
                  9: cnt = rand64();
                  default: cnt = sb.deadline + $urandom_range(0, 4) * p + ($urandom % p);
               endcase
            end
         endcase
      end
      last_fn = fn;
      w = {6'd0, idle, cnt, fn};
   endtask

   initial begin
      logic [103:0] w;
      logic [31:0]  val;
      int           guard;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      quiet = 1'b0;
      long_hold_req = 1'b0;
      last_fn = FN_START;
      settings_used = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset period: wake before any sleep, tick from zero, short and long sleeps
      issue(FN_WAKE, 64'd5, 32'd0);
      issue(FN_TICK, 64'd0, 32'hFFFF_FFFF);
      issue(FN_START, 64'd1000, 32'd0);
      issue(FN_TICK, 64'd500, 32'd0);
      issue(FN_TICK, sb.deadline + 3 * sb.eff_period() + 7, 32'd0);
      issue(FN_SLEEP, 64'd0, 32'd0);
      issue(FN_SLEEP, {64{1'b1}}, 32'd1);
      issue(FN_SLEEP, 64'd0, 32'd5);
      issue(FN_WAKE, sb.deadline + 2 * sb.eff_period(), 32'd0);
      issue(FN_SLEEP, 64'd0, 32'hFFFF_FFFF);
      issue(FN_WAKE, {64{1'b1}}, 32'd0);
      issue(FN_START, {64{1'b1}} - 10, 32'd0);
      issue(FN_TICK, 64'd5, 32'd0);
      issue(FN_TICK, 64'd200000, 32'hFFFF_FFFF);

      // zero period behaves as one: full-range elapsed count and saturation
      write_period(32'd0);
      issue(FN_START, {64{1'b1}}, 32'd0);
      issue(FN_TICK, {64{1'b1}}, 32'd0);
      issue(FN_TICK, 64'd1 << 40, 32'd0);
      issue(FN_SLEEP, 64'd0, 32'd3);
      issue(FN_WAKE, sb.deadline + 10, 32'd0);

      write_period(32'hFFFF_FFFF);
      issue(FN_START, 64'd0, 32'd0);
      issue(FN_TICK, {64{1'b1}}, 32'd0);
      issue(FN_SLEEP, 64'd0, 32'hFFFF_FFFF);
      issue(FN_WAKE, {64{1'b1}}, 32'd0);

      write_period(32'd1);
      issue(FN_START, {64{1'b1}} - 3, 32'd0);
      issue(FN_TICK, 64'd2, 32'd0);

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: val = 32'd1;
            1: val = 32'hFFFF_FFFF;
            2: val = CPT_RESET;
            3: val = 32'd0;
            4: val = $urandom_range(2, 50);
            5: val = $urandom;
            6: val = $urandom_range(1000, 200000);
            7: val = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            8: val = $urandom_range(1, 16);
            default: val = $urandom;
         endcase
         write_period(val);
         quiet = (ph == 4);
         if (ph == 2) long_hold_req = 1'b1;
         for (int i = 0; i < 155; i++) begin
            if (ph == 6 && i == 75) settle_inputs();
            next_random_word(w);
            send_word(w, pick_gap());
         end
      end

      req_tvalid <= 1'b0;
      guard = 0;
      while (sb.outstanding() != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (120) @(posedge clock);
      if (sb.outstanding() != 0)
         $display("%0d expected results never arrived", sb.outstanding());
      sb.mismatches += sb.outstanding();
      $display("covered %0d start, %0d tick, %0d sleep, %0d wake words over %0d period values",
               sb.fn_count[FN_START], sb.fn_count[FN_TICK], sb.fn_count[FN_SLEEP],
               sb.fn_count[FN_WAKE], settings_used);
      $display("%0d results checked, %0d saturated counts, %0d clamped wakes, %0d mismatches",
               sb.results_seen, sb.saturated, sb.clamped, sb.mismatches);
      if (sb.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/ttdt_pkg.sv
rtl/ttdt_arith.sv
rtl/tickless_tick_deadline_tracker.sv
rtl/ttdt_checker.sv
sim/tb_top.sv
